/* hdl/swsp_pkg.sv */
// Shared types, constants and the arctangent table of the swerve wheel setpoint block.
package swsp_pkg;

	localparam int ANG_W = 30;
	localparam int ENC_W = 13;
	localparam int SPEED_W = 16;
	localparam int GAIN_W = 16;
	localparam int SCALE_W = 12;
	localparam int CMD_W = 12;
	localparam int WHEELS = 4;
	localparam int TAB_LEN = 24;
	localparam int TAB_IDX_W = 5;
	localparam int TAB_W = 27;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic signed [ANG_W-1:0] HALF_TURN_Q16 = 30'sd268369920;
	localparam logic [ENC_W-1:0] QUARTER_POS = 13'd2048;
	localparam logic [ENC_W-1:0] QUARTER_NEG = 13'h1800;
	localparam logic signed [SPEED_W:0] SPEED_MAX = 17'sd32767;
	localparam logic signed [ENC_W:0] ENABLE_LIMIT = 14'sd200;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WHEEL0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WHEEL1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WHEEL2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WHEEL3 = 3'd5;

	typedef enum logic [2:0] {
		L_IDLE, L_ROT, L_MAG, L_SCALE, L_FIN, L_DONE
	} lane_state_t;

	typedef enum logic [2:0] {
		T_IDLE, T_PREP1, T_PREP2, T_PREP3, T_START, T_RUN
	} top_state_t;

	typedef struct packed {
		logic start;
		logic idle_cmd;
		logic ally0;
	} lane_ctrl_t;

	function automatic logic [TAB_W-1:0] atan_at(input logic [TAB_IDX_W-1:0] i);
		logic [TAB_W-1:0] v;
		case (i)
			5'd0: v = 27'd67092480;
			5'd1: v = 27'd39607004;
			5'd2: v = 27'd20927253;
			5'd3: v = 27'd10622000;
			5'd4: v = 27'd5332114;
			5'd5: v = 27'd2668656;
			5'd6: v = 27'd1334654;
			5'd7: v = 27'd667368;
			5'd8: v = 27'd333689;
			5'd9: v = 27'd166845;
			5'd10: v = 27'd83423;
			5'd11: v = 27'd41711;
			5'd12: v = 27'd20856;
			5'd13: v = 27'd10428;
			5'd14: v = 27'd5214;
			5'd15: v = 27'd2607;
			5'd16: v = 27'd1303;
			5'd17: v = 27'd652;
			5'd18: v = 27'd326;
			5'd19: v = 27'd163;
			5'd20: v = 27'd81;
			5'd21: v = 27'd41;
			5'd22: v = 27'd20;
			5'd23: v = 27'd10;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/swerve_wheel_setpoint.sv */
// Top level of the swerve wheel setpoint block: command front end, four lanes, merge.
// Usage: an input beat on s_axis carries the chassis command and the four measured
// steering angles; one output beat on m_axis carries the four folded steering errors,
// the four signed drive speeds and the drive enable mask.
// The cfg channel writes the gain, speed scale and wheel offsets; it is always ready
// and must be used only while no beat is in flight.
// An item passes the front end (divide by twelve, rotation gain, wheel vectors and lane
// start), then CORDIC_STEPS CORDIC iterations, the serial constant multiply for the
// magnitude, scaling and folding and the load of the output register, all four wheels
// in parallel.
// A new beat is taken only once the previous result has been loaded into the output
// register; the CORDIC iteration and the serial multiply take most of the time.
// s_axis_tready is high only while the block is idle. A finished result sits in the
// output register, so one further item can be processed while the receiver stalls;
// after that the block holds until m_axis_tready rises.
// Reset loads the default configuration and previous angles and empties the pipeline.
module swerve_wheel_setpoint import swsp_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// cmd_forward, cmd_side, cmd_rotate, meas_angle0..3 from bit 0 up
	input  logic [87:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// steer_err0..3, drive_speed0..3, drive_enable_mask from bit 0 up
	output logic [119:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int F = FRAC_BITS;
	localparam int NW = F + 13;
	localparam int S = NW + 4;
	localparam longint K = ((64'd1 << S) + 64'd11) / 64'd12;
	localparam int KW = F + 14;
	localparam int QW = F + 10;
	localparam int RW = F + 14;
	localparam int VW = F + 15;
	localparam int SH_R = (F < 14) ? 14 - F : 0;
	localparam int SH_L = (F >= 14) ? F - 14 : 0;
	localparam longint RND = (F < 14) ? (64'd1 << (13 - F)) : 64'd0;

	top_state_t st_q, st_d;
	logic [GAIN_W-1:0] gain_q;
	logic [SCALE_W-1:0] scale_q;
	logic [ENC_W-1:0] off_q [WHEELS];
	logic [ENC_W-1:0] prev_q [WHEELS];
	logic [ENC_W-1:0] meas_q [WHEELS];
	logic signed [CMD_W-1:0] fwd_q, side_q, rot_q;
	logic idle_q;
	logic [NW-1:0] mf_s1, ms_s1;
	logic negf_s1, negs_s1;
	logic signed [28:0] p_s1;
	logic signed [QW-1:0] vx_s2, vy_s2;
	logic signed [RW-1:0] r_s2;
	logic signed [VW-1:0] ym_s3, yp_s3, xm_s3, xp_s3;
	logic [NW+KW-1:0] qf, qs;
	logic [28:0] pa;
	logic [30:0] rr;
	logic signed [RW-1:0] r_w;
	logic signed [VW-1:0] lane_ys [WHEELS];
	logic signed [VW-1:0] lane_xs [WHEELS];
	logic [WHEELS-1:0] lane_done, lane_en;
	logic signed [ENC_W-1:0] lane_err [WHEELS];
	logic signed [SPEED_W-1:0] lane_spd [WHEELS];
	lane_ctrl_t ctrl;
	logic accept, load;
	logic signed [ENC_W-1:0] err_q [WHEELS];
	logic signed [SPEED_W-1:0] spd_q [WHEELS];
	logic [WHEELS-1:0] mask_q;
	logic out_valid_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		st_d = st_q;
		case (st_q)
			T_IDLE: if (s_axis_tvalid) st_d = T_PREP1;
			T_PREP1: st_d = T_PREP2;
			T_PREP2: st_d = T_PREP3;
			T_PREP3: st_d = T_START;
			T_START: st_d = T_RUN;
			T_RUN: if (&lane_done && (!out_valid_q || m_axis_tready)) st_d = T_IDLE;
			default: st_d = T_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (st_q == T_IDLE);
		ctrl.start = (st_q == T_START);
		ctrl.idle_cmd = idle_q;
		ctrl.ally0 = (ym_s3 == 0) && (yp_s3 == 0);
		load = (st_q == T_RUN) && (&lane_done) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			out_valid_q <= 1'b0;
			gain_q <= 16'd11585;
			scale_q <= 12'd1000;
			off_q[0] <= 13'd1797;
			off_q[1] <= 13'd3738;
			off_q[2] <= 13'd1780;
			off_q[3] <= 13'd1645;
			prev_q[0] <= 13'd1790;
			prev_q[1] <= 13'd3737;
			prev_q[2] <= 13'd1902;
			prev_q[3] <= 13'd1617;
		end else begin
			st_q <= st_d;
			if (load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (load) begin
				for (int i = 0; i < WHEELS; i++) prev_q[i] <= meas_q[i];
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ROTATION_GAIN: gain_q <= cfg_data;
					CFG_SPEED_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					CFG_OFFSET_WHEEL0: off_q[0] <= cfg_data[ENC_W-1:0];
					CFG_OFFSET_WHEEL1: off_q[1] <= cfg_data[ENC_W-1:0];
					CFG_OFFSET_WHEEL2: off_q[2] <= cfg_data[ENC_W-1:0];
					CFG_OFFSET_WHEEL3: off_q[3] <= cfg_data[ENC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		qf = NW'(mf_s1) * (NW+KW)'(K);
		qs = NW'(ms_s1) * (NW+KW)'(K);
		pa = (p_s1 < 0) ? unsigned'(-p_s1) : unsigned'(p_s1);
		rr = ((31'(pa) + 31'(RND)) >> SH_R) << SH_L;
		r_w = (p_s1 < 0) ? -$signed(rr[RW-1:0]) : $signed(rr[RW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q <= s_axis_tdata[11:0];
			side_q <= s_axis_tdata[23:12];
			rot_q <= s_axis_tdata[35:24];
			idle_q <= (s_axis_tdata[35:0] == '0);
			for (int i = 0; i < WHEELS; i++) meas_q[i] <= s_axis_tdata[36+13*i +: 13];
		end
		if (st_q == T_PREP1) begin
			mf_s1 <= ((fwd_q < 0) ? NW'(unsigned'(-13'(fwd_q))) : NW'(unsigned'(fwd_q)))
				* (NW'(1) << F) + NW'(6);
			ms_s1 <= ((side_q < 0) ? NW'(unsigned'(-13'(side_q))) : NW'(unsigned'(side_q)))
				* (NW'(1) << F) + NW'(6);
			negf_s1 <= (fwd_q < 0);
			negs_s1 <= (side_q > 0);
			p_s1 <= 29'(rot_q) * $signed({13'b0, gain_q});
		end
		if (st_q == T_PREP2) begin
			vy_s2 <= negf_s1 ? -$signed(QW'(qf >> S)) : $signed(QW'(qf >> S));
			vx_s2 <= negs_s1 ? -$signed(QW'(qs >> S)) : $signed(QW'(qs >> S));
			r_s2 <= r_w;
		end
		if (st_q == T_PREP3) begin
			ym_s3 <= VW'(vy_s2) - VW'(r_s2);
			yp_s3 <= VW'(vy_s2) + VW'(r_s2);
			xm_s3 <= VW'(vx_s2) - VW'(r_s2);
			xp_s3 <= VW'(vx_s2) + VW'(r_s2);
		end
		if (load) begin
			for (int i = 0; i < WHEELS; i++) begin
				err_q[i] <= lane_err[i];
				spd_q[i] <= lane_spd[i];
			end
			mask_q <= lane_en;
		end
	end

	assign lane_ys[0] = ym_s3;
	assign lane_xs[0] = xm_s3;
	assign lane_ys[1] = ym_s3;
	assign lane_xs[1] = xp_s3;
	assign lane_ys[2] = yp_s3;
	assign lane_xs[2] = xp_s3;
	assign lane_ys[3] = yp_s3;
	assign lane_xs[3] = xm_s3;

	for (genvar g = 0; g < WHEELS; g++) begin : g_lane
		swsp_lane #(
			.CORDIC_STEPS(CORDIC_STEPS),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.ys(lane_ys[g]),
			.xs(lane_xs[g]),
			.offset(off_q[g]),
			.meas(meas_q[g]),
			.prev(prev_q[g]),
			.speed_scale(scale_q),
			.done(lane_done[g]),
			.steer_err(lane_err[g]),
			.drive_speed(lane_spd[g]),
			.enable(lane_en[g])
		);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {mask_q, spd_q[3], spd_q[2], spd_q[1], spd_q[0],
		err_q[3], err_q[2], err_q[1], err_q[0]};

endmodule

/* hdl/swsp_lane.sv */
// One wheel lane: iterative CORDIC, serial magnitude scaling and steering error fold.
module swsp_lane import swsp_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  lane_ctrl_t ctrl,
	input  logic signed [FRAC_BITS+14:0] ys,
	input  logic signed [FRAC_BITS+14:0] xs,
	input  logic [ENC_W-1:0] offset,
	input  logic [ENC_W-1:0] meas,
	input  logic [ENC_W-1:0] prev,
	input  logic [SCALE_W-1:0] speed_scale,
	output logic done,
	output logic signed [ENC_W-1:0] steer_err,
	output logic signed [SPEED_W-1:0] drive_speed,
	output logic enable
);

	localparam int VW = FRAC_BITS + 15;
	localparam int CW = VW + 18;
	localparam int PW = CW + 16;
	localparam int MW = CW - 16;
	localparam int SPW = MW + SCALE_W;
	localparam int SW = $clog2(CORDIC_STEPS);

	lane_state_t st_q, st_d;
	logic signed [CW-1:0] a_q, b_q, a0, b0, a_nxt;
	logic signed [ANG_W-1:0] z_q;
	logic [SW-1:0] step_q;
	logic [3:0] k_q;
	logic [PW-1:0] sh_q, acc_q, acc_rnd;
	logic [SPW-1:0] prod_q;
	logic [SPW-1:0] sp_rnd;
	logic [MW-1:0] mag;
	logic [ANG_W-1:0] zabs, zsum;
	logic [ENC_W-1:0] cnt, target, diff;
	logic signed [ENC_W:0] e;
	logic signed [SPEED_W:0] spd;
	logic rev;

	always_comb begin
		st_d = st_q;
		case (st_q)
			L_IDLE, L_DONE: if (ctrl.start) st_d = L_ROT;
			L_ROT: if (step_q == SW'(CORDIC_STEPS - 1)) st_d = L_MAG;
			L_MAG: if (k_q == 4'd15) st_d = L_SCALE;
			L_SCALE: st_d = L_FIN;
			L_FIN: st_d = L_DONE;
			default: st_d = L_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == L_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	assign a0 = {{(CW-VW-16){ys[VW-1]}}, ys, 16'b0};
	assign b0 = {{(CW-VW-16){xs[VW-1]}}, xs, 16'b0};
	assign a_nxt = (b_q >= 0) ? a_q + (b_q >>> step_q) : a_q - (b_q >>> step_q);
	assign acc_rnd = acc_q + (PW'(1) << 31);
	assign mag = acc_rnd[PW-1:32];

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE, L_DONE: begin
				if (ctrl.start) begin
					step_q <= '0;
					if (ys < 0) begin
						a_q <= -a0;
						b_q <= -b0;
						z_q <= (xs >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
					end else begin
						a_q <= a0;
						b_q <= b0;
						z_q <= '0;
					end
				end
			end
			L_ROT: begin
				step_q <= step_q + SW'(1);
				a_q <= a_nxt;
				if (b_q >= 0) begin
					b_q <= b_q - (a_q >>> step_q);
					z_q <= z_q + $signed({3'b0, atan_at(TAB_IDX_W'(step_q))});
				end else begin
					b_q <= b_q + (a_q >>> step_q);
					z_q <= z_q - $signed({3'b0, atan_at(TAB_IDX_W'(step_q))});
				end
				k_q <= '0;
				acc_q <= '0;
				sh_q <= (a_nxt < 0) ? '0 : PW'(unsigned'(a_nxt));
			end
			L_MAG: begin
				k_q <= k_q + 4'd1;
				sh_q <= sh_q << 1;
				if (INV_GAIN_Q16[k_q]) acc_q <= acc_q + sh_q;
			end
			L_SCALE: prod_q <= SPW'(mag) * SPW'(speed_scale);
			L_FIN: begin
				steer_err <= e[ENC_W-1:0];
				drive_speed <= rev ? -spd[SPEED_W-1:0] : spd[SPEED_W-1:0];
				enable <= (e < ENABLE_LIMIT);
			end
			default: ;
		endcase
	end

	always_comb begin
		zabs = (z_q < 0) ? unsigned'(-z_q) : unsigned'(z_q);
		zsum = zabs + ANG_W'(32768);
		cnt = (z_q < 0) ? -zsum[16+ENC_W-1:16] : zsum[16+ENC_W-1:16];
		if (ys == 0) begin
			if (xs == 0) cnt = ctrl.ally0 ? '0 : QUARTER_NEG;
			else cnt = (xs > 0) ? QUARTER_POS : QUARTER_NEG;
		end
		target = ctrl.idle_cmd ? prev : offset + cnt;
		diff = target - meas;
		e = $signed({1'b0, diff});
		if (diff > 13'd4096) e = e - 14'sd8192;
		rev = 1'b0;
		if (e < -14'sd2048) begin
			e = e + 14'sd4096;
			rev = 1'b1;
		end else if (e > 14'sd2048) begin
			e = e - 14'sd4096;
			rev = 1'b1;
		end
		sp_rnd = (prod_q + (SPW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (ctrl.idle_cmd) spd = '0;
		else if (sp_rnd > SPW'(32767)) spd = SPEED_MAX;
		else spd = $signed({1'b0, sp_rnd[SPEED_W-1:0]});
	end

endmodule
